// ===== rtl/scct_pkg.sv =====
package scct_pkg;

    localparam int C_COORD_BITS     = 16;
    localparam int C_RADIUS_BITS    = C_COORD_BITS - 1;
    localparam int C_DIFF_BITS      = C_COORD_BITS + 1;
    localparam int C_PROD_BITS      = 2 * C_DIFF_BITS;
    localparam int C_CROSS_BITS     = C_PROD_BITS + 1;
    localparam int C_RSQ_BITS       = 2 * C_RADIUS_BITS;
    localparam int C_PART_BITS      = C_RADIUS_BITS + C_DIFF_BITS;
    localparam int C_CRSQ_BITS      = 2 * C_PROD_BITS;
    localparam int C_LIM_BITS       = C_RSQ_BITS + C_PROD_BITS;
    localparam int C_CFG_INDEX_BITS = 2;
    localparam int C_LATENCY        = 7;

    typedef enum logic [C_CFG_INDEX_BITS-1:0] {
        CFG_CENTER_X      = 2'd0,
        CFG_CENTER_Y      = 2'd1,
        CFG_CIRCLE_RADIUS = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [C_COORD_BITS-1:0] start_x;
        logic signed [C_COORD_BITS-1:0] start_y;
        logic signed [C_COORD_BITS-1:0] end_x;
        logic signed [C_COORD_BITS-1:0] end_y;
    } t_in_word;

    typedef struct packed {
        logic crossing;
        logic line_near;
    } t_out_word;

endpackage

// ===== rtl/segment_circle_crossing_test.sv =====
// channel   direction  handshake                    payload
// input     in         start, busy                  i_in (t_in_word)
// result    out        o_valid strobe, no stall     o_result (t_out_word)
// config    in         i_cfg_we, i_cfg_index        i_cfg_data
//
// one segment accepted per cycle, busy stays low
// from accept to result strobe a segment passes through seven register stages:
// differences, products, sums, abs and flags, partial squares, wide sums, compare
// synchronous active-low reset clears the stage valid bits and the config registers
// results leave on a one-cycle strobe; the receiver cannot hold them off
module segment_circle_crossing_test
    import scct_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  t_in_word                    i_in,
    output logic                        o_valid,
    output t_out_word                   o_result,
    input  logic                        i_cfg_we,
    input  logic [C_CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [C_COORD_BITS-1:0]     i_cfg_data
);

    logic signed [C_COORD_BITS-1:0]  r_center_x;
    logic signed [C_COORD_BITS-1:0]  r_center_y;
    logic        [C_RADIUS_BITS-1:0] r_radius;

    logic [C_LATENCY-1:0] r_valid;

    // stage 1
    logic signed [C_DIFF_BITS-1:0]   r_abx, r_aby, r_acx, r_acy, r_bcx, r_bcy;
    logic        [C_RADIUS_BITS-1:0] r_rad1;
    // stage 2
    logic signed [C_PROD_BITS-1:0]   r_p1, r_p2, r_sq_abx, r_sq_aby;
    logic signed [C_PROD_BITS-1:0]   r_sq_acx, r_sq_acy, r_sq_bcx, r_sq_bcy;
    logic signed [C_PROD_BITS-1:0]   r_d1x, r_d1y, r_d2x, r_d2y;
    logic        [C_RSQ_BITS-1:0]    r_rsq2;
    // stage 3
    logic signed [C_CROSS_BITS-1:0]  r_cross, r_d1, r_d2;
    logic        [C_PROD_BITS-1:0]   r_ab2, r_da, r_db;
    logic        [C_RSQ_BITS-1:0]    r_rsq3;
    // stage 4
    logic        [C_PROD_BITS-1:0]   r_cross_abs, r_ab2_4;
    logic        [C_RSQ_BITS-1:0]    r_rsq4;
    logic                            r_end_in4, r_dots_ok4;
    // stage 5
    logic        [C_PROD_BITS-1:0]   r_cr_hh, r_cr_hl, r_cr_ll;
    logic        [C_PART_BITS-1:0]   r_lim_hh, r_lim_hl, r_lim_lh, r_lim_ll;
    logic                            r_end_in5, r_dots_ok5;
    // stage 6
    logic        [C_CRSQ_BITS-1:0]   r_crsq;
    logic        [C_LIM_BITS-1:0]    r_lim;
    logic                            r_end_in6, r_dots_ok6;

    logic accept;
    logic near;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign o_valid = r_valid[C_LATENCY-1];
    assign near    = r_crsq < C_CRSQ_BITS'(r_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X:      r_center_x <= i_cfg_data;
                CFG_CENTER_Y:      r_center_y <= i_cfg_data;
                CFG_CIRCLE_RADIUS: r_radius   <= i_cfg_data[C_RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[C_LATENCY-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        // differences
        r_abx  <= C_DIFF_BITS'(i_in.end_x) - C_DIFF_BITS'(i_in.start_x);
        r_aby  <= C_DIFF_BITS'(i_in.end_y) - C_DIFF_BITS'(i_in.start_y);
        r_acx  <= C_DIFF_BITS'(r_center_x) - C_DIFF_BITS'(i_in.start_x);
        r_acy  <= C_DIFF_BITS'(r_center_y) - C_DIFF_BITS'(i_in.start_y);
        r_bcx  <= C_DIFF_BITS'(r_center_x) - C_DIFF_BITS'(i_in.end_x);
        r_bcy  <= C_DIFF_BITS'(r_center_y) - C_DIFF_BITS'(i_in.end_y);
        r_rad1 <= r_radius;

        // products
        r_p1     <= C_PROD_BITS'(r_abx) * C_PROD_BITS'(r_acy);
        r_p2     <= C_PROD_BITS'(r_aby) * C_PROD_BITS'(r_acx);
        r_sq_abx <= C_PROD_BITS'(r_abx) * C_PROD_BITS'(r_abx);
        r_sq_aby <= C_PROD_BITS'(r_aby) * C_PROD_BITS'(r_aby);
        r_sq_acx <= C_PROD_BITS'(r_acx) * C_PROD_BITS'(r_acx);
        r_sq_acy <= C_PROD_BITS'(r_acy) * C_PROD_BITS'(r_acy);
        r_sq_bcx <= C_PROD_BITS'(r_bcx) * C_PROD_BITS'(r_bcx);
        r_sq_bcy <= C_PROD_BITS'(r_bcy) * C_PROD_BITS'(r_bcy);
        r_d1x    <= C_PROD_BITS'(r_abx) * C_PROD_BITS'(r_acx);
        r_d1y    <= C_PROD_BITS'(r_aby) * C_PROD_BITS'(r_acy);
        r_d2x    <= C_PROD_BITS'(r_abx) * C_PROD_BITS'(r_bcx);
        r_d2y    <= C_PROD_BITS'(r_aby) * C_PROD_BITS'(r_bcy);
        r_rsq2   <= C_RSQ_BITS'(r_rad1) * C_RSQ_BITS'(r_rad1);

        // sums
        r_cross <= C_CROSS_BITS'(r_p1) - C_CROSS_BITS'(r_p2);
        r_d1    <= C_CROSS_BITS'(r_d1x) + C_CROSS_BITS'(r_d1y);
        r_d2    <= C_CROSS_BITS'(r_d2x) + C_CROSS_BITS'(r_d2y);
        r_ab2   <= C_PROD_BITS'(unsigned'(r_sq_abx)) + C_PROD_BITS'(unsigned'(r_sq_aby));
        r_da    <= C_PROD_BITS'(unsigned'(r_sq_acx)) + C_PROD_BITS'(unsigned'(r_sq_acy));
        r_db    <= C_PROD_BITS'(unsigned'(r_sq_bcx)) + C_PROD_BITS'(unsigned'(r_sq_bcy));
        r_rsq3  <= r_rsq2;

        // magnitude of cross and endpoint flags
        r_cross_abs <= r_cross[C_CROSS_BITS-1] ? C_PROD_BITS'(-r_cross)
                                               : C_PROD_BITS'(r_cross);
        r_ab2_4     <= r_ab2;
        r_rsq4      <= r_rsq3;
        r_end_in4   <= (r_da <= C_PROD_BITS'(r_rsq3)) || (r_db <= C_PROD_BITS'(r_rsq3));
        // second dot is taken against AB, so its sum must be at most zero
        r_dots_ok4  <= !r_d1[C_CROSS_BITS-1]
                       && (r_d2[C_CROSS_BITS-1] || (r_d2 == '0));

        // partial products of cross^2 and r^2 * |AB|^2
        r_cr_hh    <= C_PROD_BITS'(r_cross_abs[C_PROD_BITS-1:C_DIFF_BITS])
                      * C_PROD_BITS'(r_cross_abs[C_PROD_BITS-1:C_DIFF_BITS]);
        r_cr_hl    <= C_PROD_BITS'(r_cross_abs[C_PROD_BITS-1:C_DIFF_BITS])
                      * C_PROD_BITS'(r_cross_abs[C_DIFF_BITS-1:0]);
        r_cr_ll    <= C_PROD_BITS'(r_cross_abs[C_DIFF_BITS-1:0])
                      * C_PROD_BITS'(r_cross_abs[C_DIFF_BITS-1:0]);
        r_lim_hh   <= C_PART_BITS'(r_rsq4[C_RSQ_BITS-1:C_RADIUS_BITS])
                      * C_PART_BITS'(r_ab2_4[C_PROD_BITS-1:C_DIFF_BITS]);
        r_lim_hl   <= C_PART_BITS'(r_rsq4[C_RSQ_BITS-1:C_RADIUS_BITS])
                      * C_PART_BITS'(r_ab2_4[C_DIFF_BITS-1:0]);
        r_lim_lh   <= C_PART_BITS'(r_rsq4[C_RADIUS_BITS-1:0])
                      * C_PART_BITS'(r_ab2_4[C_PROD_BITS-1:C_DIFF_BITS]);
        r_lim_ll   <= C_PART_BITS'(r_rsq4[C_RADIUS_BITS-1:0])
                      * C_PART_BITS'(r_ab2_4[C_DIFF_BITS-1:0]);
        r_end_in5  <= r_end_in4;
        r_dots_ok5 <= r_dots_ok4;

        // recombine
        r_crsq     <= (C_CRSQ_BITS'(r_cr_hh) << (2 * C_DIFF_BITS))
                      + (C_CRSQ_BITS'(r_cr_hl) << (C_DIFF_BITS + 1))
                      + C_CRSQ_BITS'(r_cr_ll);
        r_lim      <= (C_LIM_BITS'(r_lim_hh) << (C_RADIUS_BITS + C_DIFF_BITS))
                      + (C_LIM_BITS'(r_lim_hl) << C_RADIUS_BITS)
                      + (C_LIM_BITS'(r_lim_lh) << C_DIFF_BITS)
                      + C_LIM_BITS'(r_lim_ll);
        r_end_in6  <= r_end_in5;
        r_dots_ok6 <= r_dots_ok5;

        // compare and output word
        o_result.line_near <= near;
        o_result.crossing  <= near && (r_end_in6 || r_dots_ok6);
    end

`ifndef SYNTHESIS
    a_cross_needs_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_result.crossing || o_result.line_near))
        else $error("crossing without near line");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_valid)
        else $error("result word missing after accept");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_radius == '0)) |-> !o_result.line_near)
        else $error("near line with zero radius");
`endif

endmodule

// ===== tb/sv/tb_segment_circle_crossing_test.sv =====
module tb_segment_circle_crossing_test;
    import scct_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [C_COORD_BITS-1:0] cx;
        logic [C_COORD_BITS-1:0] cy;
        logic [C_COORD_BITS-1:0] rad;
        t_in_word                seg;
        logic                    known;
        t_out_word               want;
    } t_probe_row;

    localparam logic [C_CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic signed [C_COORD_BITS-1:0] MIN_C = 16'sh8000;
    localparam logic signed [C_COORD_BITS-1:0] MAX_C = 16'sh7fff;
    localparam int N_PROBES    = 22;
    localparam int N_PHASES    = 10;
    localparam int PHASE_WORDS = 125;
    localparam int CYCLE_LIMIT = 200000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    t_in_word                    i_in;
    logic                        o_valid;
    t_out_word                   o_result;
    logic                        i_cfg_we;
    logic [C_CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [C_COORD_BITS-1:0]     i_cfg_data;

    // register copies used for prediction
    logic signed [C_COORD_BITS-1:0] ctr_x;
    logic signed [C_COORD_BITS-1:0] ctr_y;
    logic [C_RADIUS_BITS-1:0]       rad_mm;
    logic [C_COORD_BITS-1:0]        raw_cx;
    logic [C_COORD_BITS-1:0]        raw_cy;
    logic [C_COORD_BITS-1:0]        raw_rad;

    t_out_word pending_verdicts[$];
    t_out_word oldest_verdict;
    t_out_word typed_want;
    logic      use_typed;
    int        mismatch_count;
    int        cycle_count;

    t_probe_row probe_rows [N_PROBES] = '{
        '{16'd0, 16'd0, 16'd0, '{MIN_C, MIN_C, MAX_C, MAX_C}, 1'b1, 2'b00},
        '{16'd0, 16'd0, 16'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{-16'sd200, 16'sd0, 16'sd200, 16'sd0}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{-16'sd200, 16'sd50, 16'sd200, 16'sd50}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{-16'sd200, 16'sd100, 16'sd200, 16'sd100}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{16'sd150, 16'sd50, 16'sd300, 16'sd50}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{16'sd50, 16'sd0, 16'sd300, 16'sd0}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{16'sd100, 16'sd0, 16'sd300, 16'sd0}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{16'sd300, 16'sd300, -16'sd300, -16'sd300}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'd100, '{16'sd0, -16'sd100, 16'sd0, -16'sd400}, 1'b0, 2'b00},
        '{MIN_C, MAX_C, MAX_C, '{MAX_C, MIN_C, MIN_C, MAX_C}, 1'b0, 2'b00},
        '{MIN_C, MAX_C, MAX_C, '{MIN_C, MIN_C, MAX_C, MAX_C}, 1'b0, 2'b00},
        '{MIN_C, MAX_C, MAX_C, '{MIN_C, MAX_C, MIN_C, MAX_C}, 1'b1, 2'b00},
        '{MIN_C, MAX_C, MAX_C, '{MAX_C, MAX_C, MAX_C, MIN_C}, 1'b0, 2'b00},
        '{MAX_C, MIN_C, 16'd1, '{MAX_C, MIN_C, 16'sd32766, MIN_C}, 1'b0, 2'b00},
        '{MAX_C, MIN_C, 16'd1, '{MIN_C, MAX_C, MAX_C, MIN_C}, 1'b0, 2'b00},
        '{MAX_C, MIN_C, 16'd1, '{MAX_C, -16'sd32767, MAX_C, MAX_C}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'hffff, '{MIN_C, 16'sd0, MAX_C, 16'sd0}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'hffff, '{MIN_C, MIN_C, -16'sd32767, MIN_C}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'hffff, '{MIN_C, -16'sd32767, MAX_C, -16'sd32767}, 1'b0, 2'b00},
        '{16'd0, 16'd0, 16'hffff, '{MAX_C, MAX_C, MAX_C, MAX_C}, 1'b1, 2'b00}
    };

    segment_circle_crossing_test i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_out_word crossing_of(t_in_word w);
        longint ax, ay, bx, by, cx, cy;
        longint abx, aby, acx, acy, bcx, bcy;
        longint r2, ab2, da, db, d1, d2;
        t_wide  cr, lim;
        t_out_word res;
        ax  = longint'($signed(w.start_x));
        ay  = longint'($signed(w.start_y));
        bx  = longint'($signed(w.end_x));
        by  = longint'($signed(w.end_y));
        cx  = longint'(ctr_x);
        cy  = longint'(ctr_y);
        abx = bx - ax;
        aby = by - ay;
        acx = cx - ax;
        acy = cy - ay;
        bcx = cx - bx;
        bcy = cy - by;
        r2  = longint'(rad_mm) * longint'(rad_mm);
        ab2 = abx * abx + aby * aby;
        cr  = t_wide'(abx * acy - aby * acx);
        lim = t_wide'(r2) * t_wide'(ab2);
        da  = acx * acx + acy * acy;
        db  = bcx * bcx + bcy * bcy;
        d1  = abx * acx + aby * acy;
        d2  = -abx * bcx - aby * bcy;
        res.line_near = (cr * cr) < lim;
        res.crossing  = res.line_near && (da <= r2 || db <= r2 || (d1 >= 0 && d2 >= 0));
        return res;
    endfunction

    function automatic logic signed [C_COORD_BITS-1:0] clamp_coord(int v);
        if (v > 32767) begin
            return MAX_C;
        end
        if (v < -32768) begin
            return MIN_C;
        end
        return v[C_COORD_BITS-1:0];
    endfunction

    function automatic logic signed [C_COORD_BITS-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return MIN_C;
            1: return MAX_C;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    function automatic t_in_word random_segment();
        t_in_word w;
        int       spread;
        int       kind;
        spread = 2 * int'(rad_mm) + 4;
        kind   = $urandom_range(0, 9);
        w.start_x = clamp_coord(int'(ctr_x) + int'($urandom_range(0, 2 * spread)) - spread);
        w.start_y = clamp_coord(int'(ctr_y) + int'($urandom_range(0, 2 * spread)) - spread);
        w.end_x   = clamp_coord(int'(ctr_x) + int'($urandom_range(0, 2 * spread)) - spread);
        w.end_y   = clamp_coord(int'(ctr_y) + int'($urandom_range(0, 2 * spread)) - spread);
        if (kind < 2) begin
            w = t_in_word'({$urandom, $urandom});
        end else if (kind == 2) begin
            w.end_x = w.start_x;
            w.end_y = w.start_y;
        end else if (kind == 3) begin
            w.start_x = pick_extreme();
            w.start_y = pick_extreme();
            w.end_x   = pick_extreme();
            w.end_y   = pick_extreme();
        end
        return w;
    endfunction

    task automatic send_segment(input t_in_word w, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [C_COORD_BITS-1:0] cx,
                                input logic [C_COORD_BITS-1:0] cy,
                                input logic [C_COORD_BITS-1:0] rad);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CENTER_X;
        i_cfg_data  <= cx;
        @(negedge i_clk);
        // unmapped index must be ignored
        i_cfg_index <= CFG_UNUSED_INDEX;
        i_cfg_data  <= 16'($urandom);
        @(negedge i_clk);
        i_cfg_index <= CFG_CENTER_Y;
        i_cfg_data  <= cy;
        @(negedge i_clk);
        i_cfg_index <= CFG_CIRCLE_RADIUS;
        i_cfg_data  <= rad;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        raw_cx   = cx;
        raw_cy   = cy;
        raw_rad  = rad;
        ctr_x    = cx;
        ctr_y    = cy;
        rad_mm   = rad[C_RADIUS_BITS-1:0];
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_verdicts.size() == 0) begin
                $error("result word with none expected: %b", o_result);
                mismatch_count++;
            end else begin
                oldest_verdict = pending_verdicts.pop_front();
                if (o_result.crossing !== oldest_verdict.crossing) begin
                    $error("crossing: expected %0b, actual %0b",
                           oldest_verdict.crossing, o_result.crossing);
                    mismatch_count++;
                end
                if (o_result.line_near !== oldest_verdict.line_near) begin
                    $error("line_near: expected %0b, actual %0b",
                           oldest_verdict.line_near, o_result.line_near);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            pending_verdicts.insert(pending_verdicts.size(),
                                    use_typed ? typed_want : crossing_of(i_in));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [C_COORD_BITS-1:0] cx, cy, rad;
        logic                    burst;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_in           = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_CENTER_X;
        i_cfg_data     = '0;
        use_typed      = 1'b0;
        typed_want     = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        ctr_x          = '0;
        ctr_y          = '0;
        rad_mm         = '0;
        raw_cx         = '0;
        raw_cy         = '0;
        raw_rad        = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int n = 0; n < N_PROBES; n++) begin
            if (probe_rows[n].cx != raw_cx || probe_rows[n].cy != raw_cy ||
                probe_rows[n].rad != raw_rad) begin
                drain_results();
                write_config(probe_rows[n].cx, probe_rows[n].cy, probe_rows[n].rad);
            end
            use_typed  = probe_rows[n].known;
            typed_want = probe_rows[n].want;
            send_segment(probe_rows[n].seg, $urandom_range(0, 5));
        end
        drain_results();
        use_typed = 1'b0;

        // random phases
        for (int p = 0; p < N_PHASES; p++) begin
            cx  = 16'($urandom);
            cy  = 16'($urandom);
            rad = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
            case (p)
                0: begin
                    cx  = MIN_C;
                    cy  = MIN_C;
                    rad = 16'h7fff;
                end
                3: rad = 16'h8000;
                7: begin
                    cx  = MAX_C;
                    cy  = MIN_C;
                    rad = 16'd1;
                end
                default: ;
            endcase
            write_config(cx, cy, rad);
            burst = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                send_segment(random_segment(), burst ? 0 : $urandom_range(0, 5));
            end
            drain_results();
        end

        repeat (C_LATENCY + 3) @(negedge i_clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scct_pkg.sv
rtl/segment_circle_crossing_test.sv
tb/sv/tb_segment_circle_crossing_test.sv
